// ===== hdl/polar_iris_eye_pixel_renderer_macros.svh =====
// assertion macros shared by the renderer rtl
// no dependencies; files take it by include
`ifndef POLAR_IRIS_EYE_PIXEL_RENDERER_MACROS_SVH
`define POLAR_IRIS_EYE_PIXEL_RENDERER_MACROS_SVH

`ifndef ASSERT_OFF
`define PIEPR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PIEPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PIEPR_ASSERT_SAME(lbl, ante, cons)
`define PIEPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/piepr_pkg.sv =====
// types and constants of the polar iris eye pixel renderer
// no dependencies
`default_nettype none
package piepr_pkg;

  typedef enum logic [2:0] {
    CMD_RENDER    = 3'd0,
    CMD_LOWER_LID = 3'd1,
    CMD_UPPER_LID = 3'd2,
    CMD_SCLERA    = 3'd3,
    CMD_POLAR     = 3'd4,
    CMD_IRIS      = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_IRIS_SCALE      = 3'd0,
    REG_SCLERA_X        = 3'd1,
    REG_SCLERA_Y        = 3'd2,
    REG_UPPER_THRESHOLD = 3'd3,
    REG_LOWER_THRESHOLD = 3'd4,
    REG_LID_MIRROR      = 3'd5
  } reg_idx_t;

  localparam int CMD_W      = 3;
  localparam int IN_DATA_W  = 48;
  localparam int PIX_W      = 16;
  localparam int CFG_W      = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int COORD_W    = 7;
  localparam int TADDR_W    = 16;

  localparam int SCALE_W     = 10;
  localparam int DIST_W      = 7;
  localparam int ANGLE_W     = 9;
  localparam int SCALE_SHIFT = 7;
  localparam int ANGLE_SHIFT = 9;

  localparam logic [9:0] IRIS_SCALE_RST = 10'd512;
  localparam logic [7:0] SCLERA_X_RST   = 8'd64;
  localparam logic [7:0] SCLERA_Y_RST   = 8'd64;

endpackage
`default_nettype wire

// ===== hdl/piepr_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module piepr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/polar_iris_eye_pixel_renderer.sv =====
// Renders eye pixels from lid, sclera, polar and iris tables. A render word on in_* gives its
// byte-swapped RGB565 pixel on out_* through stages 1, 2 and 3 and the output register; the
// lid and polar tables are read in the accept cycle, the sclera and iris tables from stage 2.
// Render words and table writes sustain one per cycle while out_tready keeps the pipeline moving,
// except that a sclera or iris write waits (in_tready low, and held low while out_tready holds
// the pipeline) while a render word sits between the polar lookup and the texel lookup.
// Depends on piepr_pkg, piepr_ram and the macros header.
`default_nettype none
`include "polar_iris_eye_pixel_renderer_macros.svh"
module polar_iris_eye_pixel_renderer #(
  parameter int SCREEN_SIZE      = 128,
  parameter int SCLERA_SIZE      = 256,
  parameter int IRIS_SIZE        = 128,
  parameter int IRIS_MAP_COLUMNS = 512,
  parameter int IRIS_MAP_ROWS    = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // screen_x, screen_y, table_addr, table_data, zero pad
  input  wire logic [piepr_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd
  input  wire logic [piepr_pkg::CMD_W-1:0]         in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // pixel_color
  output logic      [piepr_pkg::PIX_W-1:0]         out_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [piepr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [piepr_pkg::CFG_W-1:0]         cfg_wdata
);
  import piepr_pkg::*;

  localparam int LID_DEPTH = SCREEN_SIZE * SCREEN_SIZE;
  localparam int SCL_DEPTH = SCLERA_SIZE * SCLERA_SIZE;
  localparam int POL_DEPTH = IRIS_SIZE * IRIS_SIZE;
  localparam int IRS_DEPTH = IRIS_MAP_ROWS * IRIS_MAP_COLUMNS;
  localparam int LID_AW    = $clog2(LID_DEPTH);
  localparam int SCL_AW    = $clog2(SCL_DEPTH);
  localparam int POL_AW    = $clog2(POL_DEPTH);
  localparam int IRS_AW    = $clog2(IRS_DEPTH);
  localparam int IRIS_OFF  = (SCLERA_SIZE - IRIS_SIZE) / 2;

  // config registers
  logic [SCALE_W-1:0] iris_scale_r;
  logic [7:0]         sclera_x_r, sclera_y_r, upper_thr_r, lower_thr_r;
  logic               lid_mirror_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iris_scale_r <= IRIS_SCALE_RST;
      sclera_x_r   <= SCLERA_X_RST;
      sclera_y_r   <= SCLERA_Y_RST;
      upper_thr_r  <= '0;
      lower_thr_r  <= '0;
      lid_mirror_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IRIS_SCALE:      iris_scale_r <= cfg_wdata;
        REG_SCLERA_X:        sclera_x_r   <= cfg_wdata[7:0];
        REG_SCLERA_Y:        sclera_y_r   <= cfg_wdata[7:0];
        REG_UPPER_THRESHOLD: upper_thr_r  <= cfg_wdata[7:0];
        REG_LOWER_THRESHOLD: lower_thr_r  <= cfg_wdata[7:0];
        REG_LID_MIRROR:      lid_mirror_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input word fields
  logic [COORD_W-1:0] in_x, in_y;
  logic [TADDR_W-1:0] in_addr;
  logic [PIX_W-1:0]   in_data;
  assign in_x    = in_tdata[6:0];
  assign in_y    = in_tdata[13:7];
  assign in_addr = in_tdata[29:14];
  assign in_data = in_tdata[45:30];

  // pipeline control
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic ld1, ld2, ld3, ld_out;
  logic late_write, late_ok, accept, render_acc;

  assign ld_out     = !out_valid_r || out_tready;
  assign ld3        = !v3_r || ld_out;
  assign ld2        = !v2_r || ld3;
  assign ld1        = !v1_r || ld2;
  assign late_write = (in_tuser == CMD_SCLERA) || (in_tuser == CMD_IRIS);
  // late tables must not change under a render word that has not read them yet
  assign late_ok    = !v1_r && (!v2_r || ld3);
  assign in_tready  = ld1 && (late_ok || !late_write);
  assign accept     = in_tvalid && in_tready;
  assign render_acc = accept && (in_tuser == CMD_RENDER);

  // table writes
  logic [18:0] addr_ext;
  logic        we_lo, we_up, we_scl, we_pol, we_irs;
  assign addr_ext = {3'b000, in_addr};
  assign we_lo  = accept && (in_tuser == CMD_LOWER_LID) && (addr_ext < 19'(LID_DEPTH));
  assign we_up  = accept && (in_tuser == CMD_UPPER_LID) && (addr_ext < 19'(LID_DEPTH));
  assign we_scl = accept && (in_tuser == CMD_SCLERA)    && (addr_ext < 19'(SCL_DEPTH));
  assign we_pol = accept && (in_tuser == CMD_POLAR)     && (addr_ext < 19'(POL_DEPTH));
  assign we_irs = accept && (in_tuser == CMD_IRIS)      && (addr_ext < 19'(IRS_DEPTH));

  // stage 0: lid and polar addresses
  logic [8:0]         x9, y9, lid_x, sx0, sy0;
  logic [16:0]        lid_idx, pol_idx;
  logic signed [10:0] ix0, iy0;
  logic               off_screen0, in_iris0;

  always_comb begin
    x9          = {2'b00, in_x};
    y9          = {2'b00, in_y};
    off_screen0 = (x9 >= 9'(SCREEN_SIZE)) || (y9 >= 9'(SCREEN_SIZE));
    lid_x       = lid_mirror_r ? x9 : 9'(SCREEN_SIZE - 1) - x9;
    lid_idx     = 17'(y9 * 17'(SCREEN_SIZE)) + {8'b0, lid_x};
    sx0         = {1'b0, sclera_x_r} + x9;
    sy0         = {1'b0, sclera_y_r} + y9;
    ix0         = $signed({2'b00, sx0}) - $signed(11'(IRIS_OFF));
    iy0         = $signed({2'b00, sy0}) - $signed(11'(IRIS_OFF));
    in_iris0    = !ix0[10] && !iy0[10] &&
                  (ix0 < $signed(11'(IRIS_SIZE))) && (iy0 < $signed(11'(IRIS_SIZE)));
    pol_idx     = 17'(iy0[8:0] * 17'(IRIS_SIZE)) + {8'b0, ix0[8:0]};
  end

  logic [7:0]       lo_rd, up_rd;
  logic [PIX_W-1:0] pol_rd, scl_rd, irs_rd;

  piepr_ram #(.WIDTH(8), .DEPTH(LID_DEPTH)) u_lower_lid (
    .clk, .we(we_lo), .waddr(LID_AW'(in_addr)), .wdata(in_data[7:0]),
    .re(ld1), .raddr(LID_AW'(lid_idx)), .rdata(lo_rd)
  );

  piepr_ram #(.WIDTH(8), .DEPTH(LID_DEPTH)) u_upper_lid (
    .clk, .we(we_up), .waddr(LID_AW'(in_addr)), .wdata(in_data[7:0]),
    .re(ld1), .raddr(LID_AW'(lid_idx)), .rdata(up_rd)
  );

  piepr_ram #(.WIDTH(PIX_W), .DEPTH(POL_DEPTH)) u_polar (
    .clk, .we(we_pol), .waddr(POL_AW'(in_addr)), .wdata(in_data),
    .re(ld1), .raddr(POL_AW'(pol_idx)), .rdata(pol_rd)
  );

  // stage 1
  logic [8:0] sx1_r, sy1_r;
  logic       off1_r, iris1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= render_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      sx1_r   <= sx0;
      sy1_r   <= sy0;
      off1_r  <= off_screen0;
      iris1_r <= in_iris0;
    end
  end

  function automatic logic [8:0] wrap_scl(input logic [8:0] v);
    logic [9:0] t;
    t = {1'b0, v};
    if (t >= 10'(SCLERA_SIZE)) t = t - 10'(SCLERA_SIZE);
    if (t >= 10'(SCLERA_SIZE)) t = t - 10'(SCLERA_SIZE);
    return t[8:0];
  endfunction

  logic        covered1;
  logic [16:0] dist_prod1;
  logic [18:0] ang_prod1;
  logic [8:0]  sxw1, syw1;
  logic [18:0] scl_row1;

  always_comb begin
    covered1   = (lo_rd <= lower_thr_r) || (up_rd <= upper_thr_r);
    dist_prod1 = iris_scale_r * pol_rd[DIST_W-1:0];
    ang_prod1  = 19'(pol_rd[15:DIST_W] * 19'(IRIS_MAP_COLUMNS));
    sxw1       = wrap_scl(sx1_r);
    syw1       = wrap_scl(sy1_r);
    scl_row1   = 19'(syw1 * 19'(SCLERA_SIZE));
  end

  // stage 2
  logic        black2_r, iris2_r;
  logic [16:0] dist_prod2_r;
  logic [9:0]  ang2_r;
  logic [8:0]  sxw2_r;
  logic [18:0] scl_row2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ld2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      black2_r     <= off1_r || covered1;
      iris2_r      <= iris1_r;
      dist_prod2_r <= dist_prod1;
      ang2_r       <= ang_prod1[18:ANGLE_SHIFT];
      sxw2_r       <= sxw1;
      scl_row2_r   <= scl_row1;
    end
  end

  logic [9:0]  dist2;
  logic        use_iris2;
  logic [16:0] irs_idx2;
  logic [18:0] scl_idx2;

  always_comb begin
    dist2     = dist_prod2_r[16:SCALE_SHIFT];
    use_iris2 = iris2_r && (dist2 < 10'(IRIS_MAP_ROWS));
    irs_idx2  = 17'(dist2[6:0] * 17'(IRIS_MAP_COLUMNS)) + {7'b0, ang2_r};
    scl_idx2  = scl_row2_r + {10'b0, sxw2_r};
  end

  piepr_ram #(.WIDTH(PIX_W), .DEPTH(SCL_DEPTH)) u_sclera (
    .clk, .we(we_scl), .waddr(SCL_AW'(in_addr)), .wdata(in_data),
    .re(ld3), .raddr(SCL_AW'(scl_idx2)), .rdata(scl_rd)
  );

  piepr_ram #(.WIDTH(PIX_W), .DEPTH(IRS_DEPTH)) u_iris (
    .clk, .we(we_irs), .waddr(IRS_AW'(in_addr)), .wdata(in_data),
    .re(ld3), .raddr(IRS_AW'(irs_idx2)), .rdata(irs_rd)
  );

  // stage 3
  logic black3_r, use_iris3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ld3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      black3_r    <= black2_r;
      use_iris3_r <= use_iris2;
    end
  end

  logic [PIX_W-1:0] pix3, out_tdata_nxt;

  always_comb begin
    priority if (black3_r) begin
      pix3 = '0;
    end else if (use_iris3_r) begin
      pix3 = irs_rd;
    end else begin
      pix3 = scl_rd;
    end
    out_tdata_nxt = {pix3[7:0], pix3[15:8]};
  end

  // output register
  logic [PIX_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  `PIEPR_ASSERT_SAME(a_late_write_order, accept && late_write, !v1_r && (!v2_r || ld3))
  `PIEPR_ASSERT_NEXT(a_stage3_holds, v3_r && !ld_out, v3_r && out_valid_r)
  `PIEPR_ASSERT_NEXT(a_black_is_zero, v3_r && ld_out && black3_r, out_tdata_r == '0)
  `PIEPR_ASSERT_NEXT(a_out_from_stage3, !out_valid_r && !v3_r, !out_valid_r)

endmodule
`default_nettype wire
